[design/pfc_pkg.sv]
// Shared constants, types and sequencer states for the prime filter chain.
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int VALUE_W    = 31;
  localparam int CELLS      = 64;
  localparam int COUNT_W    = $clog2(CELLS + 1);
  localparam int BITCNT_W   = $clog2(VALUE_W);
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = (CELLS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_W      = GROUPS * GROUP_SIZE;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_REDUCE,
    S_DECIDE
  } state_e;

  // Broadcast from the sequencer to every cell and to the hit tree.
  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_val;
    logic reduce;
  } seq_ctrl_t;

  // Outcome of one candidate.
  typedef struct packed {
    logic               emit;
    logic               store;
    logic [VALUE_W-1:0] value;
    logic               unchecked;
  } result_t;

endpackage

[design/pfc_cell.sv]
// One filter cell: stored divisor and a bit-serial restoring remainder.
`timescale 1ns / 1ps
module pfc_cell (
  input  logic                        clk_i,
  input  pfc_pkg::seq_ctrl_t          ctrl_i,
  input  logic                        wr_i,
  input  logic [pfc_pkg::VALUE_W-1:0] wr_value_i,
  output logic                        zero_rem_o
);
  import pfc_pkg::*;

  logic [VALUE_W-1:0] div_q;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W:0]   trial;
  logic [VALUE_W:0]   diff;

  // Shift the next candidate bit in, subtract when it fits.
  always_comb begin
    trial = {rem_q, ctrl_i.bit_val};
    diff  = trial - {1'b0, div_q};
    rem_d = rem_q;
    if (ctrl_i.clear) begin
      rem_d = '0;
    end else if (ctrl_i.shift) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[VALUE_W-1:0];
      end else begin
        rem_d = trial[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (wr_i) begin
      div_q <= wr_value_i;
    end
  end

  assign zero_rem_o = (rem_q == '0);

endmodule

[design/pfc_ctrl.sv]
// Sequencer: input capture, serial bit feed, verdict and divisor count.
`timescale 1ns / 1ps
module pfc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pfc_pkg::VALUE_W-1:0] candidate_i,
  input  logic                        hit_any_i,
  input  logic                        out_busy_i,
  output pfc_pkg::seq_ctrl_t          ctrl_o,
  output pfc_pkg::result_t            result_o,
  output logic [pfc_pkg::COUNT_W-1:0] count_o
);
  import pfc_pkg::*;

  state_e              state_q, state_d;
  logic [VALUE_W-1:0]  cand_q, cand_d;
  logic [VALUE_W-1:0]  sh_q, sh_d;
  logic [BITCNT_W-1:0] bitcnt_q, bitcnt_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                accept;
  logic                survivor;
  logic                full;
  logic                finish;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign full     = (count_q == COUNT_W'(CELLS));
  assign survivor = (cand_q >= VALUE_W'(2)) && !hit_any_i;
  // A survivor waits while the previous word is still held at the output.
  assign finish   = (state_q == S_DECIDE) && !(survivor && out_busy_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SHIFT;
      S_SHIFT:  if (bitcnt_q == '0) state_d = S_REDUCE;
      S_REDUCE: state_d = S_DECIDE;
      S_DECIDE: if (finish) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o     = (state_q != S_IDLE);
    ctrl_o.clear   = accept;
    ctrl_o.shift   = (state_q == S_SHIFT);
    ctrl_o.bit_val = sh_q[VALUE_W-1];
    ctrl_o.reduce  = (state_q == S_REDUCE);
    result_o.emit      = finish && survivor;
    result_o.store     = finish && survivor && !full;
    result_o.value     = cand_q;
    result_o.unchecked = full;
  end

  // Datapath
  always_comb begin
    cand_d   = cand_q;
    sh_d     = sh_q;
    bitcnt_d = bitcnt_q;
    count_d  = count_q;
    if (accept) begin
      cand_d   = candidate_i;
      sh_d     = candidate_i;
      bitcnt_d = BITCNT_W'(VALUE_W - 1);
    end else if (state_q == S_SHIFT) begin
      sh_d     = {sh_q[VALUE_W-2:0], 1'b0};
      bitcnt_d = bitcnt_q - BITCNT_W'(1);
    end
    if (result_o.store) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    sh_q     <= sh_d;
    bitcnt_q <= bitcnt_d;
  end

  assign count_o = count_q;

endmodule

[design/prime_filter_chain.sv]
// Top level: trial-division prime filter built from a row of bit-serial cells.
// Path: an accepted candidate runs through 31 bit-serial remainder steps,
//   one hit-tree stage and one verdict state before its word is registered.
// Candidates are taken one at a time; a survivor also waits for a free output.
// Reset (rst_ni low, asynchronous): sequencer idle, divisor count zero,
//   output word empty; stored divisors are not cleared.
`timescale 1ns / 1ps
module prime_filter_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pfc_pkg::VALUE_W-1:0] candidate_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pfc_pkg::VALUE_W-1:0] prime_value_o,
  output logic                        unchecked_o
);
  import pfc_pkg::*;

  seq_ctrl_t          ctrl;
  result_t            result;
  logic [COUNT_W-1:0] count;
  logic [CELLS-1:0]   zero_rem;
  logic [CELLS-1:0]   cell_hit;
  logic [PAD_W-1:0]   hit_pad;
  logic [GROUPS-1:0]  group_hit_q;
  logic               hit_any;
  logic               out_busy;

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] prime_value_q;
  logic               unchecked_q;

  // Output register holds one finished word, so the sequencer can take the
  // next candidate while the consumer is stalled.
  assign out_busy = out_valid_q && out_stall_i;

  pfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .candidate_i (candidate_i),
    .hit_any_i   (hit_any),
    .out_busy_i  (out_busy),
    .ctrl_o      (ctrl),
    .result_o    (result),
    .count_o     (count)
  );

  // Row of cells. Cell k is occupied once the count has passed k; only
  // occupied cells may veto a candidate. A new divisor lands in the first
  // free cell.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    pfc_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .wr_i       (result.store && (count == COUNT_W'(k))),
      .wr_value_i (result.value),
      .zero_rem_o (zero_rem[k])
    );
    assign cell_hit[k] = zero_rem[k] && (COUNT_W'(k) < count);
  end

  // Hit tree: groups of eight cells are ORed into registers, then the
  // verdict ORs the group bits.
  assign hit_pad = PAD_W'(cell_hit);

  for (genvar g = 0; g < GROUPS; g++) begin : g_group
    always_ff @(posedge clk_i) begin
      if (ctrl.reduce) begin
        group_hit_q[g] <= |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
      end
    end
  end

  assign hit_any = |group_hit_q;

  always_comb begin
    out_valid_d = out_busy || result.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.emit) begin
      prime_value_q <= result.value;
      unchecked_q   <= result.unchecked;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = prime_value_q;
  assign unchecked_o   = unchecked_q;

endmodule

[design/pfc_checker.sv]
// Port-level checker for the prime filter chain, bound to the top level.
`timescale 1ns / 1ps
module pfc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [pfc_pkg::VALUE_W-1:0] prime_value_o,
  input logic                        unchecked_o
);
  import pfc_pkg::*;

  // A held word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(prime_value_o) && $stable(unchecked_o))
    else $error("output word dropped or changed while stalled");

  // Every emitted word is at least two.
  a_min_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prime_value_o >= VALUE_W'(2)))
    else $error("emitted value below two");

  // After taking a word the filter is busy with the serial test.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while a test is running");

  // A new word only appears at the end of a test.
  a_emit_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a running test");

endmodule

bind prime_filter_chain pfc_checker u_pfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .prime_value_o (prime_value_o),
  .unchecked_o   (unchecked_o)
);

[dv/tb.sv]
// Self-checking testbench for the prime filter chain: scoreboard, drivers and watchdog.
`timescale 1ns / 1ps
module tb;
  import pfc_pkg::*;

  localparam int HOLD_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_WAIT = 80;    // idle wait after the last owed word has arrived
  localparam int RANDOM_N   = 700;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               unchecked;
  } prime_word_t;

  // Trial-division predictor plus the queue of primes still owed by the block.
  class sieve_board;
    logic [VALUE_W-1:0] divisors[CELLS];
    int unsigned        n_stored;
    prime_word_t        primes_due[$];
    int unsigned        errors;
    int unsigned        n_words;
    int unsigned        n_unchecked;

    function new();
      n_stored    = 0;
      errors      = 0;
      n_words     = 0;
      n_unchecked = 0;
    endfunction

    function void note_candidate(logic [VALUE_W-1:0] v);
      prime_word_t w;
      bit          hit;
      hit = 1'b0;
      if (v < 2) return;
      for (int i = 0; i < n_stored; i++)
        if (v % divisors[i] == 0) hit = 1'b1;
      if (hit) return;
      w.value = v;
      if (n_stored < CELLS) begin
        divisors[n_stored] = v;
        n_stored++;
        w.unchecked = 1'b0;
      end else begin
        w.unchecked = 1'b1;
      end
      primes_due.push_back(w);
    endfunction

    function void check_word(logic [VALUE_W-1:0] pv, logic unc);
      prime_word_t w;
      n_words++;
      if (unc) n_unchecked++;
      if (primes_due.size() == 0) begin
        $display("%0t: unexpected word value=%0d unchecked=%0b", $time, pv, unc);
        errors++;
        return;
      end
      w = primes_due.pop_front();
      if (pv !== w.value) begin
        $display("%0t: prime_value expected %0d actual %0d", $time, w.value, pv);
        errors++;
      end
      if (unc !== w.unchecked) begin
        $display("%0t: unchecked expected %0b actual %0b (value %0d)",
                 $time, w.unchecked, unc, w.value);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [VALUE_W-1:0] candidate_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [VALUE_W-1:0] prime_value_o;
  logic               unchecked_o;

  sieve_board  sb = new();
  bit          calm = 1'b0;   // no idling on either side while set
  int unsigned n_sent = 0;

  prime_filter_chain u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .candidate_i   (candidate_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .prime_value_o (prime_value_o),
    .unchecked_o   (unchecked_o)
  );

  always #2 clk_i = ~clk_i;

  // Random idle cycles, then hold the word until the block takes it.
  task automatic send_candidate(input logic [VALUE_W-1:0] v);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_candidate(v);
    n_sent++;
  endtask

  // Output side: check every accepted word, stall at random while not calm.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(prime_value_o, unchecked_o);
    out_stall_i <= !calm && ($urandom_range(99) < 29);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < HOLD_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, %0d words still expected", $time, sb.primes_due.size());
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] directed[$];
    logic [VALUE_W-1:0] run;
    logic [VALUE_W-1:0] v;
    logic [31:0]        r;
    int unsigned        pick;

    // Below two, repeats, squares of stored primes, the largest values,
    // a value that is both prime and the field maximum, then a few repeats.
    directed = '{0, 1, 2, 2, 3, 4, 5, 9, 25, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 7, 49, 1, 0,
                 31'h7FFF_FFFE, 31'h4000_0000, 6, 11, 13, 31'h3FFF_FFFF, 15, 17};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_candidate(directed[i]);

    // Mostly an ascending stream that fills the table and then runs into
    // unchecked survivors; the rest jumps, noise, repeats and tiny values.
    run = VALUE_W'(18);
    for (int n = 0; n < RANDOM_N; n++) begin
      calm = (n >= 250 && n < 400);
      pick = $urandom_range(99);
      r    = $urandom;
      if (pick < 62) begin
        v   = run;
        run = run + VALUE_W'(1);
      end else if (pick < 72) begin
        run = r[VALUE_W-1:0];
        v   = run;
        run = run + VALUE_W'(1);
      end else if (pick < 84) begin
        v = r[VALUE_W-1:0];
      end else if (pick < 89) begin
        v = VALUE_W'($urandom_range(1));
      end else if (pick < 95) begin
        v = run - VALUE_W'($urandom_range(1, 8));
      end else begin
        v = VALUE_W'($urandom_range(2, 400));
      end
      send_candidate(v);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.primes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("tb: %0d candidates in, %0d primes out, %0d of them unchecked",
             n_sent, sb.n_words, sb.n_unchecked);
    $display("tb: %0d divisors stored of %0d cells", sb.n_stored, CELLS);
    if (sb.errors == 0 && sb.primes_due.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
